@@ rtl/hrlp_pkg.sv @@
package hrlp_pkg;

    // Width of the saturating good and bad line counters.
    localparam int COUNT_BITS = 16;
    // Width of the count fields in a result transfer.
    localparam int CountFieldW = 16;

    localparam logic [6:0] RecordLen  = 7'd86;
    localparam logic [6:0] RegFirst   = 7'd69;
    localparam logic [6:0] RegLast    = 7'd75;
    localparam logic [6:0] IdLast     = 7'd5;
    localparam logic [6:0] DecodedMax = 7'd127;

    localparam logic [7:0] CharLf = 8'h0A;
    localparam logic [7:0] CharCr = 8'h0D;

    typedef enum logic {
        InChar = 1'b0,
        InEnd  = 1'b1
    } t_in_kind;

    typedef enum logic {
        ResByte    = 1'b0,
        ResVerdict = 1'b1
    } t_res_kind;

    typedef enum logic [2:0] {
        FldId       = 3'd0,
        FldOwner    = 3'd1,
        FldAirfield = 3'd2,
        FldType     = 3'd3,
        FldReg      = 3'd4,
        FldCallsign = 3'd5,
        FldFreq     = 3'd6,
        FldGap      = 3'd7
    } t_field;

    // What the line parser needs to know about one character.
    typedef struct packed {
        logic       eol;
        logic       hex_ok;
        logic [3:0] nibble;
    } t_char_info;

    function automatic logic is_space(input logic [7:0] c);
        return (c == 8'h20) || ((c >= 8'h09) && (c <= 8'h0D)) ||
               (c == 8'h85) || (c == 8'hA0);
    endfunction

    function automatic t_field field_of(input logic [6:0] p);
        t_field f;
        if (p <= 7'd5)       f = FldId;
        else if (p <= 7'd26) f = FldOwner;
        else if (p <= 7'd47) f = FldAirfield;
        else if (p <= 7'd67) f = FldType;
        else if (p == 7'd68) f = FldGap;
        else if (p <= 7'd75) f = FldReg;
        else if (p <= 7'd78) f = FldCallsign;
        else if (p <= 7'd85) f = FldFreq;
        else                 f = FldGap;
        return f;
    endfunction

endpackage

@@ rtl/hrlp_if.sv @@
interface hrlp_in_if;
    import hrlp_pkg::*;

    logic       valid;
    logic       ready;
    logic       kind;
    logic [7:0] char_code;

    modport source (output valid, output kind, output char_code, input ready);
    modport sink   (input valid, input kind, input char_code, output ready);
endinterface

interface hrlp_out_if;
    import hrlp_pkg::*;

    logic                   valid;
    logic                   ready;
    logic                   result_kind;
    logic [7:0]             byte_value;
    logic [6:0]             byte_position;
    logic [2:0]             field_index;
    logic                   line_good;
    logic [CountFieldW-1:0] good_count;
    logic [CountFieldW-1:0] bad_count;

    modport source (
        output valid, output result_kind, output byte_value, output byte_position,
        output field_index, output line_good, output good_count, output bad_count,
        input ready
    );
    modport sink (
        input valid, input result_kind, input byte_value, input byte_position,
        input field_index, input line_good, input good_count, input bad_count,
        output ready
    );
endinterface

@@ rtl/hrlp_char_class.sv @@
module hrlp_char_class (
    input  logic [7:0]          i_char,
    output hrlp_pkg::t_char_info o_info
);
    import hrlp_pkg::*;

    always_comb begin
        o_info.eol    = (i_char == CharLf) || (i_char == CharCr);
        o_info.hex_ok = 1'b0;
        o_info.nibble = 4'd0;
        if ((i_char >= 8'h30) && (i_char <= 8'h39)) begin
            o_info.hex_ok = 1'b1;
            o_info.nibble = i_char[3:0];
        end else if (((i_char >= 8'h41) && (i_char <= 8'h46)) ||
                     ((i_char >= 8'h61) && (i_char <= 8'h66))) begin
            // Letters A-F and a-f share the low bits 1..6.
            o_info.hex_ok = 1'b1;
            o_info.nibble = i_char[3:0] + 4'd9;
        end
    end

endmodule

@@ rtl/hex_record_line_parser_top.sv @@
// Hex record line parser. Text arrives one Latin-1 character per input transfer
// (kind 0), and kind 1 marks the end of data: the open line gets its verdict and
// all state, counters included, returns to the reset state. CR and LF end lines,
// empty lines are skipped and the first nonempty line is a header that yields
// nothing. On other lines each pair of hex digits gives one decoded byte transfer
// with its position and field, and each line end gives a verdict transfer with
// the saturating good and bad line counts. The block takes one input transfer in
// every cycle while ready is high; a result passes through the input register
// and then the result register, around the combinational line update. Ready
// falls only while the result register holds an untaken result and the input
// register holds an item waiting behind it.
module hex_record_line_parser_top (
    input  logic       i_clk,
    input  logic       i_rst_n,
    hrlp_in_if.sink    i_in,
    hrlp_out_if.source o_out
);
    import hrlp_pkg::*;

    localparam logic [COUNT_BITS-1:0] CountMax = {COUNT_BITS{1'b1}};

    // Input register.
    logic       r_in_valid;
    logic       r_in_kind;
    logic [7:0] r_in_char;

    // Line state.
    logic                  r_header_pending, n_header_pending;
    logic                  r_line_open,      n_line_open;
    logic                  r_pair_half,      n_pair_half;
    logic [4:0]            r_first_nibble,   n_first_nibble;
    logic [6:0]            r_decoded_count,  n_decoded_count;
    logic [1:0]            r_id_ends_ok,     n_id_ends_ok;
    logic                  r_reg_seen,       n_reg_seen;
    logic [COUNT_BITS-1:0] r_good_total,     n_good_total;
    logic [COUNT_BITS-1:0] r_bad_total,      n_bad_total;

    // Result register.
    logic                  r_out_valid,    n_out_valid;
    t_res_kind             r_out_kind,     n_out_kind;
    logic [7:0]            r_out_byte,     n_out_byte;
    logic [6:0]            r_out_pos,      n_out_pos;
    t_field                r_out_field,    n_out_field;
    logic                  r_out_good,     n_out_good;
    logic [COUNT_BITS-1:0] r_out_good_cnt, n_out_good_cnt;
    logic [COUNT_BITS-1:0] r_out_bad_cnt,  n_out_bad_cnt;

    t_char_info char_info;
    logic       advance;
    logic       emit;
    logic       line_good;
    logic [7:0] dec_byte;

    hrlp_char_class u_char_class (
        .i_char (r_in_char),
        .o_info (char_info)
    );

    // The stored item moves on whenever the result register is free or being taken.
    assign advance    = !r_out_valid || o_out.ready;
    assign i_in.ready = !r_in_valid || advance;

    assign line_good = (r_decoded_count == RecordLen) && (r_id_ends_ok == 2'b11) &&
                       r_reg_seen;
    assign dec_byte  = {r_first_nibble[3:0], char_info.nibble};

    always_comb begin
        n_header_pending = r_header_pending;
        n_line_open      = r_line_open;
        n_pair_half      = r_pair_half;
        n_first_nibble   = r_first_nibble;
        n_decoded_count  = r_decoded_count;
        n_id_ends_ok     = r_id_ends_ok;
        n_reg_seen       = r_reg_seen;
        n_good_total     = r_good_total;
        n_bad_total      = r_bad_total;

        emit           = 1'b0;
        n_out_kind     = r_out_kind;
        n_out_byte     = r_out_byte;
        n_out_pos      = r_out_pos;
        n_out_field    = r_out_field;
        n_out_good     = r_out_good;
        n_out_good_cnt = r_out_good_cnt;
        n_out_bad_cnt  = r_out_bad_cnt;

        if (r_in_valid && advance) begin
            if ((r_in_kind == InEnd) || char_info.eol) begin
                // A line end closes the open line: the header just passes, any
                // other line gets a verdict carrying the updated counts.
                if (r_line_open && r_header_pending) begin
                    n_header_pending = 1'b0;
                end else if (r_line_open) begin
                    emit = 1'b1;
                    if (line_good) begin
                        if (r_good_total != CountMax) begin
                            n_good_total = r_good_total + 1'b1;
                        end
                    end else if (r_bad_total != CountMax) begin
                        n_bad_total = r_bad_total + 1'b1;
                    end
                    n_out_kind     = ResVerdict;
                    n_out_byte     = 8'd0;
                    n_out_pos      = 7'd0;
                    n_out_field    = FldId;
                    n_out_good     = line_good;
                    n_out_good_cnt = n_good_total;
                    n_out_bad_cnt  = n_bad_total;
                end
                n_line_open     = 1'b0;
                n_pair_half     = 1'b0;
                n_first_nibble  = 5'd0;
                n_decoded_count = 7'd0;
                n_id_ends_ok    = 2'b00;
                n_reg_seen      = 1'b0;
                // End of data also starts over with a fresh header and counts.
                if (r_in_kind == InEnd) begin
                    n_header_pending = 1'b1;
                    n_good_total     = '0;
                    n_bad_total      = '0;
                end
            end else begin
                n_line_open = 1'b1;
                if (!r_header_pending) begin
                    if (!r_pair_half) begin
                        n_first_nibble = {char_info.hex_ok, char_info.nibble};
                        n_pair_half    = 1'b1;
                    end else begin
                        n_pair_half    = 1'b0;
                        n_first_nibble = 5'd0;
                        if (r_first_nibble[4] && char_info.hex_ok) begin
                            emit = 1'b1;
                            if (r_decoded_count != DecodedMax) begin
                                n_decoded_count = r_decoded_count + 7'd1;
                            end
                            if ((r_decoded_count == 7'd0) && !is_space(dec_byte)) begin
                                n_id_ends_ok[0] = 1'b1;
                            end
                            if ((r_decoded_count == IdLast) && !is_space(dec_byte)) begin
                                n_id_ends_ok[1] = 1'b1;
                            end
                            if ((r_decoded_count >= RegFirst) &&
                                (r_decoded_count <= RegLast) && !is_space(dec_byte)) begin
                                n_reg_seen = 1'b1;
                            end
                            n_out_kind     = ResByte;
                            n_out_byte     = dec_byte;
                            n_out_pos      = r_decoded_count;
                            n_out_field    = field_of(r_decoded_count);
                            n_out_good     = 1'b0;
                            n_out_good_cnt = r_good_total;
                            n_out_bad_cnt  = r_bad_total;
                        end
                    end
                end
            end
        end

        if (advance) begin
            n_out_valid = r_in_valid && emit;
        end else begin
            n_out_valid = r_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid       <= 1'b0;
            r_header_pending <= 1'b1;
            r_line_open      <= 1'b0;
            r_pair_half      <= 1'b0;
            r_first_nibble   <= 5'd0;
            r_decoded_count  <= 7'd0;
            r_id_ends_ok     <= 2'b00;
            r_reg_seen       <= 1'b0;
            r_good_total     <= '0;
            r_bad_total      <= '0;
            r_out_valid      <= 1'b0;
        end else begin
            if (i_in.ready) begin
                r_in_valid <= i_in.valid;
            end
            r_header_pending <= n_header_pending;
            r_line_open      <= n_line_open;
            r_pair_half      <= n_pair_half;
            r_first_nibble   <= n_first_nibble;
            r_decoded_count  <= n_decoded_count;
            r_id_ends_ok     <= n_id_ends_ok;
            r_reg_seen       <= n_reg_seen;
            r_good_total     <= n_good_total;
            r_bad_total      <= n_bad_total;
            r_out_valid      <= n_out_valid;
        end
    end

    // Payload registers carry no reset.
    always_ff @(posedge i_clk) begin
        if (i_in.ready) begin
            r_in_kind <= i_in.kind;
            r_in_char <= i_in.char_code;
        end
        r_out_kind     <= n_out_kind;
        r_out_byte     <= n_out_byte;
        r_out_pos      <= n_out_pos;
        r_out_field    <= n_out_field;
        r_out_good     <= n_out_good;
        r_out_good_cnt <= n_out_good_cnt;
        r_out_bad_cnt  <= n_out_bad_cnt;
    end

    assign o_out.valid         = r_out_valid;
    assign o_out.result_kind   = r_out_kind;
    assign o_out.byte_value    = r_out_byte;
    assign o_out.byte_position = r_out_pos;
    assign o_out.field_index   = r_out_field;
    assign o_out.line_good     = r_out_good;
    assign o_out.good_count    = CountFieldW'(r_out_good_cnt);
    assign o_out.bad_count     = CountFieldW'(r_out_bad_cnt);

endmodule
